FILE: rtl/core/asue_pkg.sv
// shared types, constants and state codes for the ams sketch block
package asue_pkg;

	localparam int ROWS_DEF    = 5;
	localparam int BUCKETS_DEF = 256;

	localparam int CFG_IW = 3;
	localparam int CFG_DW = 32;
	localparam int REG_W  = 31;

	localparam logic [CFG_IW-1:0] CFG_PRIME  = 3'd0;
	localparam logic [CFG_IW-1:0] CFG_CUBIC  = 3'd1;
	localparam logic [CFG_IW-1:0] CFG_SQUARE = 3'd2;
	localparam logic [CFG_IW-1:0] CFG_LINEAR = 3'd3;
	localparam logic [CFG_IW-1:0] CFG_OFFSET = 3'd4;

	localparam logic [REG_W-1:0] PRIME_RST  = 31'h7FFF_FFFF;
	localparam logic [REG_W-1:0] CUBIC_RST  = 31'd1;
	localparam logic [REG_W-1:0] SQUARE_RST = 31'd2;
	localparam logic [REG_W-1:0] LINEAR_RST = 31'd3;
	localparam logic [REG_W-1:0] OFFSET_RST = 31'd4;

	localparam logic ACT_UPDATE = 1'b0;
	localparam logic ACT_QUERY  = 1'b1;

	typedef struct packed {
		logic               action;
		logic        [63:0] item_key;
		logic signed [31:0] item_weight;
	} cmd_t;

	typedef struct packed {
		logic        result_kind;
		logic [63:0] median_square_sum;
		logic [31:0] estimate_root;
	} result_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_COEF_GO,
		ST_COEF_WAIT,
		ST_MUL0,
		ST_MUL1,
		ST_MUL2,
		ST_MADD,
		ST_PMOD_GO,
		ST_PMOD_WAIT,
		ST_BMOD_GO,
		ST_BMOD_WAIT,
		ST_RD,
		ST_RMW,
		ST_Q_RD,
		ST_Q_SQ,
		ST_Q_ACC,
		ST_MED_LOAD,
		ST_MED_CMP,
		ST_MED_NEXT,
		ST_SQRT_GO,
		ST_SQRT_WAIT,
		ST_DONE
	} state_t;

endpackage

FILE: rtl/core/ams_sketch_update_estimate.sv
// top level: ams sketch counter memory, update and query sequencer
// After reset the counter memory is cleared one entry a cycle with busy high;
// configuration writes are taken throughout. An update works row by row: four
// coefficient reductions, the hash polynomial on three 32x32 partial products, and a
// parity reduction, each reduction in the serial remainder unit, then a bucket
// reduction by reciprocal multiplication over 16-bit chunks and a read-modify-write
// of the counter, with busy high. A query reads every counter once, picks the median
// and takes a square root, with busy high. One command is in flight at a time; start
// is taken when busy is low, and the result appears for one cycle with done high.
// The receiver cannot stall it and must take it in that cycle.
module ams_sketch_update_estimate #(
	parameter int ROWS    = asue_pkg::ROWS_DEF,
	parameter int BUCKETS = asue_pkg::BUCKETS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  asue_pkg::cmd_t              cmd,
	output logic                        busy,
	output logic                        done,
	output asue_pkg::result_t           result,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [asue_pkg::CFG_IW-1:0] cfg_index,
	input  logic [asue_pkg::CFG_DW-1:0] cfg_data
);
	import asue_pkg::*;

	localparam int DEPTH = ROWS * BUCKETS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int BW    = $clog2(BUCKETS);
	localparam int CW    = $clog2(ROWS + 1);

	// floor(2^28 / BUCKETS), quotient estimate is low by at most one
	localparam logic [27:0] BRECIP = 28'((64'd1 << 28) / BUCKETS);

	state_t state_q, state_d;

	logic [REG_W-1:0] prime_q, cubic_q, square_q, linear_q, offset_q;
	logic [REG_W-1:0] m_eff;

	logic [AW-1:0] clr_q;
	logic [RW-1:0] row_q;
	logic [BW-1:0] bucket_q;
	logic [1:0]    cix_q;
	logic [1:0]    hstep_q;
	logic [RW-1:0] mi_q;
	logic [RW-1:0] mj_q;
	logic [CW-1:0] lt_q, le_q;
	logic [2:0]    bstep_q;

	logic               act_q;
	logic [63:0]        key_q;
	logic signed [31:0] weight_q;
	logic [REG_W-1:0]   coef_q [4];
	logic [63:0]        acc_q;
	logic [63:0]        prod_q;
	logic [31:0]        cross_q, cross2_q;
	logic               sign_q;
	logic [63:0]        sq_q;
	logic               ovf_q;
	logic [63:0]        ring_q [ROWS];
	logic [63:0]        cand_q;
	logic [63:0]        med_q;
	logic [31:0]        root_q;
	logic [63:0]        bx_q;
	logic [27:0]        by_q;
	logic [27:0]        bq_q;
	logic [11:0]        brem_q;

	logic [63:0] mem [DEPTH];
	logic [63:0] rdata_q;
	logic [AW-1:0] addr;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [63:0]   mem_wdata;

	logic        mod_start, mod_done;
	logic [63:0] mod_dvd;
	logic [30:0] mod_div;
	logic [31:0] mod_rem;
	logic        sqrt_start, sqrt_done;
	logic [31:0] sqrt_root;

	logic [63:0] wext;
	logic [63:0] mag;
	logic [64:0] sum_full;
	logic [63:0] acc_next;
	logic [63:0] seed_sel;
	logic [27:0] by_y;
	logic [55:0] bprod;
	logic [27:0] bdiff;
	logic [27:0] bfix;

	assign m_eff     = (prime_q < 31'd2) ? 31'd2 : prime_q;
	assign wext      = {{32{weight_q[31]}}, weight_q};
	assign addr      = AW'(row_q) * AW'(BUCKETS) + AW'(bucket_q);
	assign mag       = rdata_q[63] ? (64'd0 - rdata_q) : rdata_q;
	assign sum_full  = {1'b0, acc_q} + {1'b0, sq_q};
	assign acc_next  = (ovf_q || sum_full[64]) ? 64'hFFFF_FFFF_FFFF_FFFF : sum_full[63:0];
	assign cfg_ready = 1'b1;

	// bucket reduction: fold the next 16-bit chunk into the running remainder
	assign by_y  = {brem_q, bx_q[63:48]};
	assign bprod = 56'(by_y) * 56'(BRECIP);
	assign bdiff = by_q - bq_q * 28'(BUCKETS);
	assign bfix  = (bdiff >= 28'(BUCKETS)) ? (bdiff - 28'(BUCKETS)) : bdiff;

	always_comb begin
		unique case (cix_q)
			2'd0:    seed_sel = 64'(cubic_q);
			2'd1:    seed_sel = 64'(square_q);
			2'd2:    seed_sel = 64'(linear_q);
			default: seed_sel = 64'(offset_q);
		endcase
	end

	asue_mod u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mod_start),
		.dividend  (mod_dvd),
		.divisor   (mod_div),
		.done      (mod_done),
		.remainder (mod_rem)
	);

	asue_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.value  (med_q),
		.done   (sqrt_done),
		.root   (sqrt_root)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:     if (clr_q == AW'(DEPTH - 1)) state_d = ST_IDLE;
			ST_IDLE: begin
				if (start) state_d = (cmd.action == ACT_QUERY) ? ST_Q_RD : ST_COEF_GO;
			end
			ST_COEF_GO:   state_d = ST_COEF_WAIT;
			ST_COEF_WAIT: begin
				if (mod_done) state_d = (cix_q == 2'd3) ? ST_MUL0 : ST_COEF_GO;
			end
			ST_MUL0:      state_d = ST_MUL1;
			ST_MUL1:      state_d = ST_MUL2;
			ST_MUL2:      state_d = ST_MADD;
			ST_MADD:      state_d = (hstep_q == 2'd3) ? ST_PMOD_GO : ST_MUL0;
			ST_PMOD_GO:   state_d = ST_PMOD_WAIT;
			ST_PMOD_WAIT: if (mod_done) state_d = ST_BMOD_GO;
			ST_BMOD_GO:   state_d = ST_BMOD_WAIT;
			ST_BMOD_WAIT: if (bstep_q == 3'd7) state_d = ST_RD;
			ST_RD:        state_d = ST_RMW;
			ST_RMW:       state_d = (row_q == RW'(ROWS - 1)) ? ST_DONE : ST_COEF_GO;
			ST_Q_RD:      state_d = ST_Q_SQ;
			ST_Q_SQ:      state_d = ST_Q_ACC;
			ST_Q_ACC: begin
				if (bucket_q == BW'(BUCKETS - 1) && row_q == RW'(ROWS - 1)) begin
					state_d = ST_MED_LOAD;
				end else begin
					state_d = ST_Q_RD;
				end
			end
			ST_MED_LOAD:  state_d = ST_MED_CMP;
			ST_MED_CMP:   if (mj_q == RW'(ROWS - 1)) state_d = ST_MED_NEXT;
			ST_MED_NEXT:  state_d = (mi_q == RW'(ROWS - 1)) ? ST_SQRT_GO : ST_MED_LOAD;
			ST_SQRT_GO:   state_d = ST_SQRT_WAIT;
			ST_SQRT_WAIT: if (sqrt_done) state_d = ST_DONE;
			ST_DONE:      state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// unit controls and memory write port
	always_comb begin
		mod_start  = 1'b0;
		mod_dvd    = 64'(seed_sel) + 64'(row_q);
		mod_div    = m_eff;
		sqrt_start = 1'b0;
		mem_we     = 1'b0;
		mem_waddr  = addr;
		mem_wdata  = sign_q ? (rdata_q + wext) : (rdata_q - wext);
		busy       = (state_q != ST_IDLE);
		done       = (state_q == ST_DONE);
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			ST_COEF_GO: mod_start = 1'b1;
			ST_PMOD_GO: begin
				mod_start = 1'b1;
				mod_dvd   = acc_q;
			end
			ST_RMW:     mem_we = 1'b1;
			ST_SQRT_GO: sqrt_start = 1'b1;
			default: begin
			end
		endcase
		result.result_kind       = act_q;
		result.median_square_sum = (act_q == ACT_QUERY) ? med_q : 64'd0;
		result.estimate_root     = (act_q == ACT_QUERY) ? root_q : 32'd0;
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		rdata_q <= mem[addr];
	end

	// control state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			row_q    <= '0;
			bucket_q <= '0;
			cix_q    <= '0;
			hstep_q  <= 2'd1;
			mi_q     <= '0;
			mj_q     <= '0;
			lt_q     <= '0;
			le_q     <= '0;
			bstep_q  <= '0;
			act_q    <= ACT_UPDATE;
			prime_q  <= PRIME_RST;
			cubic_q  <= CUBIC_RST;
			square_q <= SQUARE_RST;
			linear_q <= LINEAR_RST;
			offset_q <= OFFSET_RST;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_PRIME:  prime_q  <= cfg_data[REG_W-1:0];
					CFG_CUBIC:  cubic_q  <= cfg_data[REG_W-1:0];
					CFG_SQUARE: square_q <= cfg_data[REG_W-1:0];
					CFG_LINEAR: linear_q <= cfg_data[REG_W-1:0];
					CFG_OFFSET: offset_q <= cfg_data[REG_W-1:0];
					default: begin
					end
				endcase
			end
			unique case (state_q)
				ST_CLEAR: clr_q <= clr_q + AW'(1);
				ST_IDLE: begin
					if (start) begin
						act_q    <= cmd.action;
						row_q    <= '0;
						bucket_q <= '0;
						cix_q    <= '0;
						hstep_q  <= 2'd1;
						mi_q     <= '0;
					end
				end
				ST_COEF_WAIT: if (mod_done) cix_q <= cix_q + 2'd1;
				ST_MADD:      hstep_q <= hstep_q + 2'd1;
				ST_BMOD_GO:   bstep_q <= '0;
				ST_BMOD_WAIT: begin
					bstep_q <= bstep_q + 3'd1;
					if (bstep_q == 3'd7) bucket_q <= bfix[BW-1:0];
				end
				ST_RMW: begin
					row_q   <= row_q + RW'(1);
					cix_q   <= '0;
					hstep_q <= 2'd1;
				end
				ST_Q_ACC: begin
					if (bucket_q == BW'(BUCKETS - 1)) begin
						bucket_q <= '0;
						row_q    <= row_q + RW'(1);
					end else begin
						bucket_q <= bucket_q + BW'(1);
					end
				end
				ST_MED_LOAD: begin
					mj_q <= '0;
					lt_q <= '0;
					le_q <= '0;
				end
				ST_MED_CMP: begin
					mj_q <= mj_q + RW'(1);
					if (ring_q[0] < cand_q) lt_q <= lt_q + CW'(1);
					if (ring_q[0] <= cand_q) le_q <= le_q + CW'(1);
				end
				ST_MED_NEXT: mi_q <= mi_q + RW'(1);
				default: begin
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					key_q    <= cmd.item_key;
					weight_q <= cmd.item_weight;
					acc_q    <= '0;
				end
			end
			ST_COEF_WAIT: begin
				if (mod_done) begin
					coef_q[cix_q] <= mod_rem[REG_W-1:0];
					if (cix_q == 2'd0) acc_q <= 64'(mod_rem);
				end
			end
			ST_MUL0: prod_q   <= acc_q[31:0] * key_q[31:0];
			ST_MUL1: cross_q  <= 32'(acc_q[63:32] * key_q[31:0]);
			ST_MUL2: cross2_q <= 32'(acc_q[31:0] * key_q[63:32]);
			// low 64 bits of acc*key plus the next coefficient
			ST_MADD: acc_q <= prod_q + {cross_q + cross2_q, 32'd0} + 64'(coef_q[hstep_q]);
			ST_PMOD_WAIT: if (mod_done) sign_q <= mod_rem[0];
			ST_BMOD_GO: begin
				bx_q   <= 64'(key_q * row_q) + 64'(row_q);
				brem_q <= '0;
			end
			ST_BMOD_WAIT: begin
				if (!bstep_q[0]) begin
					by_q <= by_y;
					bq_q <= bprod[55:28];
				end else begin
					brem_q <= bfix[11:0];
					bx_q   <= {bx_q[47:0], 16'd0};
				end
			end
			ST_Q_SQ: begin
				ovf_q <= (mag[63:32] != 32'd0);
				sq_q  <= mag[31:0] * mag[31:0];
			end
			ST_Q_ACC: begin
				if (bucket_q == BW'(BUCKETS - 1)) begin
					acc_q               <= '0;
					ring_q[ROWS-1]      <= acc_next;
					for (int i = 0; i < ROWS - 1; i++) ring_q[i] <= ring_q[i+1];
				end else begin
					acc_q <= acc_next;
				end
			end
			ST_MED_LOAD: cand_q <= ring_q[0];
			ST_MED_CMP, ST_MED_NEXT: begin
				// rotate so every row sum passes the fixed compare point
				ring_q[ROWS-1] <= ring_q[0];
				for (int i = 0; i < ROWS - 1; i++) ring_q[i] <= ring_q[i+1];
				if (state_q == ST_MED_NEXT && lt_q <= CW'(ROWS / 2) && le_q > CW'(ROWS / 2)) begin
					med_q <= cand_q;
				end
			end
			ST_SQRT_WAIT: if (sqrt_done) root_q <= sqrt_root;
			default: begin
			end
		endcase
	end
endmodule

FILE: rtl/core/asue_mod.sv
// serial remainder unit: 64-bit dividend by a 31-bit divisor, one bit per cycle
module asue_mod (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [30:0] divisor,
	output logic        done,
	output logic [31:0] remainder
);
	import asue_pkg::*;

	logic [63:0] dvd_q;
	logic [31:0] rem_q;
	logic [30:0] div_q;
	logic [5:0]  cnt_q;
	logic        run_q;
	logic        done_q;
	logic [32:0] trial;
	logic [31:0] rem_next;

	always_comb begin
		trial = {rem_q, dvd_q[63]};
		if (trial >= {2'b00, div_q}) begin
			rem_next = 32'(trial - {2'b00, div_q});
		end else begin
			rem_next = trial[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			dvd_q <= {dvd_q[62:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;
endmodule

FILE: rtl/core/asue_sqrt.sv
// serial floor square root of a 64-bit value, one result bit per cycle
module asue_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] value,
	output logic        done,
	output logic [31:0] root
);
	import asue_pkg::*;

	logic [63:0] v_q;
	logic [63:0] root_q;
	logic [63:0] bit_q;
	logic [4:0]  cnt_q;
	logic        run_q;
	logic        done_q;
	logic [63:0] trial;

	assign trial = root_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q    <= value;
			root_q <= '0;
			bit_q  <= 64'h4000_0000_0000_0000;
		end else if (run_q) begin
			if (v_q >= trial) begin
				v_q    <= v_q - trial;
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = root_q[31:0];
endmodule

FILE: tb/sv/ams_sketch_update_estimate_test.sv
// testbench for the ams sketch block: scoreboard, command and config drivers, stimulus
`timescale 1ns / 1ps

import asue_pkg::*;

class sketch_scoreboard;
	localparam int NR = ROWS_DEF;
	localparam int NB = BUCKETS_DEF;

	logic [63:0] counters [NR][NB];
	logic [REG_W-1:0] regs [5];
	result_t awaited [$];
	int errors;
	int updates;
	int queries;

	function new();
		foreach (counters[r, b])
			counters[r][b] = '0;
		regs[CFG_PRIME]  = PRIME_RST;
		regs[CFG_CUBIC]  = CUBIC_RST;
		regs[CFG_SQUARE] = SQUARE_RST;
		regs[CFG_LINEAR] = LINEAR_RST;
		regs[CFG_OFFSET] = OFFSET_RST;
		errors = 0;
		updates = 0;
		queries = 0;
	endfunction

	function void write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
		// indexes past the last register are dropped by the block
		if (idx <= CFG_OFFSET)
			regs[idx] = data[REG_W-1:0];
	endfunction

	function logic [31:0] int_sqrt(logic [63:0] v);
		logic [31:0] root;
		logic [31:0] trial;
		logic [63:0] t64;
		root = '0;
		for (int i = 31; i >= 0; i--) begin
			trial = root | (32'd1 << i);
			t64 = {32'd0, trial};
			if (t64 * t64 <= v)
				root = trial;
		end
		return root;
	endfunction

	function void note_cmd(cmd_t c);
		logic [63:0] m, key, w, rr, ca, cb, cc, cd, poly, slot, mag, sq;
		logic [64:0] acc;
		logic [63:0] sums [NR];
		logic [63:0] tmp;
		result_t r;
		r = '0;
		if (c.action == ACT_UPDATE) begin
			updates++;
			m = (regs[CFG_PRIME] < 2) ? 64'd2 : {33'd0, regs[CFG_PRIME]};
			key = c.item_key;
			w = {{32{c.item_weight[31]}}, c.item_weight};
			for (int row = 0; row < NR; row++) begin
				rr = row;
				slot = (key * rr + rr) % NB;
				ca = ({33'd0, regs[CFG_CUBIC]} + rr) % m;
				cb = ({33'd0, regs[CFG_SQUARE]} + rr) % m;
				cc = ({33'd0, regs[CFG_LINEAR]} + rr) % m;
				cd = ({33'd0, regs[CFG_OFFSET]} + rr) % m;
				poly = ca * key * key * key + cb * key * key + cc * key + cd;
				if (((poly % m) & 64'd1) != 0)
					counters[row][slot] = counters[row][slot] + w;
				else
					counters[row][slot] = counters[row][slot] - w;
			end
			r.result_kind = 1'b0;
		end else begin
			queries++;
			for (int row = 0; row < NR; row++) begin
				acc = '0;
				for (int b = 0; b < NB; b++) begin
					mag = counters[row][b][63] ? -counters[row][b] : counters[row][b];
					sq = (mag[63:32] != 0) ? '1 : mag * mag;
					acc = acc + sq;
					if (acc[64])
						acc = {1'b0, 64'hFFFF_FFFF_FFFF_FFFF};
				end
				sums[row] = acc[63:0];
			end
			for (int a = 1; a < NR; a++)
				for (int b = a; b > 0 && sums[b-1] > sums[b]; b--) begin
					tmp = sums[b];
					sums[b] = sums[b-1];
					sums[b-1] = tmp;
				end
			r.result_kind = 1'b1;
			r.median_square_sum = sums[NR/2];
			r.estimate_root = int_sqrt(sums[NR/2]);
		end
		awaited.push_back(r);
	endfunction

	function void check_result(result_t got);
		result_t want;
		if (awaited.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("unexpected result: %p", got);
			return;
		end
		want = awaited.pop_front();
		if (got.result_kind !== want.result_kind
				|| got.median_square_sum !== want.median_square_sum
				|| got.estimate_root !== want.estimate_root) begin
			errors++;
			if (errors <= 10)
				$display("mismatch at %0t: kind %0d/%0d sum %h/%h root %h/%h", $realtime,
					want.result_kind, got.result_kind, want.median_square_sum,
					got.median_square_sum, want.estimate_root, got.estimate_root);
		end
	endfunction
endclass

module ams_sketch_update_estimate_test;
	logic clk;
	logic arst_n;
	logic start;
	cmd_t cmd;
	logic busy;
	logic done;
	result_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IW-1:0] cfg_index;
	logic [CFG_DW-1:0] cfg_data;

	sketch_scoreboard sb;
	int idle_pct;
	int cfg_writes;
	logic [63:0] key_pool [16];

	ams_sketch_update_estimate dut (
		.clk(clk), .arst_n(arst_n), .start(start), .cmd(cmd), .busy(busy), .done(done),
		.result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#200_000_000;
		$display("ams_sketch_update_estimate_test NOT OK");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(result);
	end

	task automatic send_cmd(logic act, logic [63:0] key, logic [31:0] weight);
		cmd_t c;
		c.action = act;
		c.item_key = key;
		c.item_weight = weight;
		if ($urandom_range(99) < idle_pct)
			repeat ($urandom_range(1, 6)) @(negedge clk);
		@(negedge clk);
		start <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (busy);
		sb.note_cmd(c);
		@(negedge clk);
		start <= 1'b0;
		cmd <= '0;
	endtask

	task automatic write_cfg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		while (sb.awaited.size() != 0)
			@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic set_all(logic [31:0] p, logic [31:0] a, logic [31:0] b, logic [31:0] c,
			logic [31:0] d);
		drain();
		write_cfg(CFG_PRIME, p);
		write_cfg(CFG_CUBIC, a);
		write_cfg(CFG_SQUARE, b);
		write_cfg(CFG_LINEAR, c);
		write_cfg(CFG_OFFSET, d);
	endtask

	// large weight followed later by its negation so counters return and stay in range
	task automatic random_item();
		logic [63:0] key;
		logic [31:0] w;
		int pick;
		pick = $urandom_range(99);
		key = ($urandom_range(1)) ? key_pool[$urandom_range(15)] : {$urandom, $urandom};
		if (pick < 15) begin
			send_cmd(ACT_QUERY, {$urandom, $urandom}, $urandom);
		end else if (pick < 25) begin
			w = $urandom;
			if (w == 32'h8000_0000)
				w = 32'h7FFF_FFFF;
			send_cmd(ACT_UPDATE, key, w);
			if ($urandom_range(1))
				send_cmd(ACT_QUERY, {$urandom, $urandom}, $urandom);
			send_cmd(ACT_UPDATE, key, -w);
		end else begin
			w = $urandom_range(131070) - 65535;
			send_cmd(ACT_UPDATE, key, w);
		end
	endtask

	initial begin
		sb = new();
		idle_pct = 23;
		cfg_writes = 0;
		start = 1'b0;
		cmd = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		foreach (key_pool[i])
			key_pool[i] = {$urandom, $urandom};
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: field extremes, squared counter and row sum saturation, ignored fields
		send_cmd(ACT_QUERY, '0, '0);
		send_cmd(ACT_UPDATE, '0, '0);
		send_cmd(ACT_UPDATE, '1, 32'h8000_0000);
		send_cmd(ACT_UPDATE, 64'd1, 32'h7FFF_FFFF);
		send_cmd(ACT_QUERY, '1, '1);
		send_cmd(ACT_UPDATE, '1, 32'h4000_0000);
		send_cmd(ACT_UPDATE, '1, 32'h4000_0000);
		send_cmd(ACT_UPDATE, 64'd1, 32'h8000_0001);
		repeat (4) send_cmd(ACT_UPDATE, 64'h0123_4567_89AB_CDEF, 32'h7FFF_FFFF);
		send_cmd(ACT_QUERY, 64'h5555_5555_5555_5555, 32'hAAAA_AAAA);
		repeat (4) send_cmd(ACT_UPDATE, 64'h0123_4567_89AB_CDEF, 32'h8000_0001);
		send_cmd(ACT_QUERY, 64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555);

		for (int seg = 0; seg < 6; seg++) begin
			idle_pct = (seg < 2) ? 23 : (seg < 4) ? 46 : 0;
			case (seg)
				0: set_all({1'b0, $urandom}, $urandom, $urandom, $urandom, $urandom);
				1: begin
					set_all(32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
					write_cfg(3'd5, $urandom);
					write_cfg(3'd7, $urandom);
				end
				2: set_all(32'd1, 32'd0, 32'd0, 32'd0, 32'd0);
				3: set_all(32'd2, $urandom, $urandom, $urandom, $urandom);
				4: set_all(32'h7FFF_FFFF, 32'hFFFF_FFFF, $urandom, $urandom, 32'h8000_0000);
				default: set_all($urandom_range(1000, 3), $urandom, $urandom, $urandom,
					$urandom);
			endcase
			repeat (85) random_item();
		end

		drain();
		repeat (50) @(posedge clk);
		$display("ran %0d updates and %0d queries across %0d register writes",
			sb.updates, sb.queries, cfg_writes);
		$display("%0d mismatches, %0d results never arrived", sb.errors, sb.awaited.size());
		if (sb.errors == 0 && sb.awaited.size() == 0)
			$display("ams_sketch_update_estimate_test OK");
		else
			$display("ams_sketch_update_estimate_test NOT OK");
		$finish;
	end
endmodule
